>>> hdl/cstp_pkg.sv
// Package for the call stack exclusive time profiler.
// Holds field widths, opcode and status codes, and the sequencer state type.
// No dependencies.
package cstp_pkg;

    localparam int NUM_FUNCS_DEF   = 16;
    localparam int STACK_DEPTH_DEF = 64;

    localparam int OPW   = 2;
    localparam int IDW   = 4;
    localparam int TSW   = 32;
    localparam int TOTW  = 40;
    localparam int STW   = 3;
    localparam int FCW   = 5;
    localparam int DELTW = TSW + 1;

    localparam logic [FCW-1:0]  FC_RESET  = 5'd16;
    localparam logic [TOTW-1:0] TOTAL_MAX = '1;
    localparam logic [TSW-1:0]  TIME_MAX  = '1;

    localparam logic [OPW-1:0] OP_START = 2'd0;
    localparam logic [OPW-1:0] OP_END   = 2'd1;

    typedef enum logic [STW-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_ID    = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_BACKWARDS = 3'd4
    } status_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_EXEC = 1'b1
    } seq_state_t;

endpackage

>>> hdl/cstp_cell.sv
// One call stack cell: holds a function id, shifts with its neighbors.
// Depends on cstp_pkg.
module cstp_cell
    import cstp_pkg::*;
(
    input  logic           clk,
    input  logic           push,
    input  logic           pop,
    input  logic [IDW-1:0] from_up,
    input  logic [IDW-1:0] from_down,
    output logic [IDW-1:0] q
);

    logic [IDW-1:0] id_reg;
    logic [IDW-1:0] id_next;

    always_comb
    begin
        id_next = id_reg;
        if (push)
        begin
            id_next = from_up;
        end
        else if (pop)
        begin
            id_next = from_down;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign q = id_reg;

endmodule

>>> hdl/cstp_totals.sv
// Per-function exclusive time totals: one memory, registered read,
// valid bits so unwritten entries read as zero. Depends on cstp_pkg.
module cstp_totals
    import cstp_pkg::*;
#(
    parameter int NUM_FUNCS = NUM_FUNCS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(NUM_FUNCS)-1:0] rd_addr,
    output logic [TOTW-1:0]              rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_FUNCS)-1:0] wr_addr,
    input  logic [TOTW-1:0]              wr_data
);

    logic [TOTW-1:0]      mem [NUM_FUNCS];
    logic [NUM_FUNCS-1:0] vld_reg;
    logic [TOTW-1:0]      rd_raw_reg;
    logic                 rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_raw_reg : '0;

endmodule

>>> hdl/call_stack_exclusive_time_profiler.sv
// Call stack exclusive time profiler: top level.
// Each request runs in two phases: decode and stack shift on accept, then, once
// the output register is free, saturating update of the totals memory. A new
// request is taken only after the previous one has left the update phase.
// Reset: asynchronous, active low; empties the stack, zeroes time mark and
// all totals (valid bits), function_count returns to 16. Uses cstp_pkg.
module call_stack_exclusive_time_profiler
    import cstp_pkg::*;
#(
    parameter int NUM_FUNCS   = NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    // configuration: function_count
    input  logic           cfg_we,
    input  logic [FCW-1:0] cfg_wdata,
    // request stream
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [39:0]    s_tdata,   // opcode[1:0], func_id[5:2], timestamp[37:6], zero pad
    // result stream
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [47:0]    m_tdata    // credited_id[3:0], total_time[43:4], status[46:44], pad
);

    localparam int FW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam logic [LW-1:0] LVL_FULL = LW'(STACK_DEPTH);

    // ---------------- request fields ----------------
    logic [OPW-1:0] in_op;
    logic [IDW-1:0] in_id;
    logic [TSW-1:0] in_ts;

    assign in_op = s_tdata[1:0];
    assign in_id = s_tdata[5:2];
    assign in_ts = s_tdata[37:6];

    // ---------------- state ----------------
    seq_state_t      state_reg, state_next;
    logic [FCW-1:0]  fcount_reg;
    logic [LW-1:0]   level_reg, level_next;
    logic [TSW-1:0]  mark_reg, mark_next;

    // item registers between the two phases
    logic [IDW-1:0]   tgt_reg, tgt_next;
    status_t          status_reg, status_next;
    logic             credit_reg, credit_next;
    logic [DELTW-1:0] delta_reg, delta_next;
    logic             hide_reg, hide_next;     // report a zero total

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [47:0]      out_data_reg, out_data_next;

    // ---------------- stack chain ----------------
    logic                 push, pop;
    logic [IDW-1:0]       stk_q [STACK_DEPTH];
    logic [IDW-1:0]       top_id;

    assign top_id = stk_q[0];

    // Cell 0 is the top of stack; a push shifts everything down one cell,
    // a pop shifts it up.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [IDW-1:0] up_d;
        logic [IDW-1:0] down_d;
        if (i == 0)
        begin : g_first
            assign up_d = in_id;
        end
        else
        begin : g_mid_up
            assign up_d = stk_q[i-1];
        end
        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign down_d = '0;
        end
        else
        begin : g_mid_down
            assign down_d = stk_q[i+1];
        end
        cstp_cell u_cell (
            .clk       (clk),
            .push      (push),
            .pop       (pop),
            .from_up   (up_d),
            .from_down (down_d),
            .q         (stk_q[i])
        );
    end

    // ---------------- totals memory ----------------
    logic            rd_en;
    logic [FW-1:0]   rd_addr;
    logic [TOTW-1:0] rd_data;
    logic            wr_en;
    logic [FW-1:0]   wr_addr;
    logic [TOTW-1:0] wr_data;
    logic [IDW+FW-1:0] tgt_ext_c;
    logic [IDW+FW-1:0] tgt_ext_r;

    assign tgt_ext_c = {{FW{1'b0}}, tgt_next};
    assign tgt_ext_r = {{FW{1'b0}}, tgt_reg};
    assign rd_addr   = tgt_ext_c[FW-1:0];
    assign wr_addr   = tgt_ext_r[FW-1:0];

    cstp_totals #(
        .NUM_FUNCS (NUM_FUNCS)
    ) u_totals (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // ---------------- decode ----------------
    logic            id_ok;
    logic            top_ok;
    logic            ts_back;
    logic            accept;
    logic            out_free;
    logic [TOTW:0]   sum;
    logic [TOTW-1:0] new_total;

    // id must be below both the programmed count and the table size
    assign id_ok   = ({1'b0, in_id} < fcount_reg) && (32'(in_id) < NUM_FUNCS);
    // the running function may have dropped out of range since it was pushed
    assign top_ok  = ({1'b0, top_id} < fcount_reg) && (32'(top_id) < NUM_FUNCS);
    assign ts_back = in_ts < mark_reg;
    assign accept  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // saturating credit of the fetched total
    assign sum       = {1'b0, rd_data} + (TOTW+1)'(delta_reg);
    assign new_total = sum[TOTW] ? TOTAL_MAX : sum[TOTW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        mark_next      = mark_reg;
        tgt_next       = in_id;
        status_next    = status_reg;
        credit_next    = credit_reg;
        delta_next     = delta_reg;
        hide_next      = hide_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        push           = 1'b0;
        pop            = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_data        = new_total;
        s_tready       = 1'b0;

        case (state_reg)
            SEQ_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    // decode picks the target, checks errors and shifts the stack
                    state_next  = SEQ_EXEC;
                    rd_en       = 1'b1;
                    credit_next = 1'b0;
                    status_next = ST_OK;
                    hide_next   = !id_ok;
                    delta_next  = {1'b0, in_ts} - {1'b0, mark_reg};
                    if (!id_ok)
                    begin
                        status_next = ST_BAD_ID;
                    end
                    else if (in_op == OP_START)
                    begin
                        if (level_reg >= LVL_FULL)
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else if (ts_back)
                        begin
                            status_next = ST_BACKWARDS;
                        end
                        else
                        begin
                            push       = 1'b1;
                            level_next = level_reg + 1'b1;
                            mark_next  = in_ts;
                            if (level_reg != '0)
                            begin
                                // running function gets ts - mark; an out-of-range
                                // caller is still credited but reads back as zero
                                tgt_next    = top_id;
                                credit_next = 1'b1;
                                hide_next   = !top_ok;
                            end
                        end
                    end
                    else if (in_op == OP_END)
                    begin
                        if (level_reg == '0)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else if (ts_back)
                        begin
                            status_next = ST_BACKWARDS;
                        end
                        else
                        begin
                            // popped function gets ts - mark + 1
                            pop         = 1'b1;
                            level_next  = level_reg - 1'b1;
                            tgt_next    = top_id;
                            credit_next = 1'b1;
                            delta_next  = {1'b0, in_ts} - {1'b0, mark_reg} + 1'b1;
                            mark_next   = (in_ts == TIME_MAX) ? TIME_MAX : in_ts + 1'b1;
                        end
                    end
                end
            end
            SEQ_EXEC:
            begin
                tgt_next = tgt_reg;
                if (out_free)
                begin
                    state_next     = SEQ_IDLE;
                    wr_en          = credit_reg;
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[3:0]   = tgt_reg;
                    out_data_next[46:44] = status_reg;
                    if (hide_reg)
                    begin
                        out_data_next[43:4] = '0;
                    end
                    else if (credit_reg)
                    begin
                        out_data_next[43:4] = new_total;
                    end
                    else
                    begin
                        out_data_next[43:4] = rd_data;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            fcount_reg    <= FC_RESET;
            level_reg     <= '0;
            mark_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                fcount_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg      <= tgt_next;
        status_reg   <= status_next;
        credit_reg   <= credit_next;
        delta_reg    <= delta_next;
        hide_reg     <= hide_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // stack level never passes the stack depth
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_FULL)
        else $error("stack level beyond depth");

    // an accepted request is always followed by the update phase
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == SEQ_EXEC)
        else $error("request accepted without update phase");

    // bad ids never report a total
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[46:44] == ST_BAD_ID) |-> m_tdata[43:4] == '0)
        else $error("bad id with nonzero total");

    // the stack only moves on an accepted request
    a_stack_move: assert property (@(posedge clk) disable iff (!rst_n)
        (push || pop) |-> accept)
        else $error("stack shifted without a request");
`endif

endmodule

>>> tb/call_stack_exclusive_time_profiler_tb.sv
// Testbench for call_stack_exclusive_time_profiler: streams start, end and read requests,
// predicts each result from its own profile of the call stack and compares field by field.
// Depends on cstp_pkg and the profiler RTL only.
module call_stack_exclusive_time_profiler_tb;
    import cstp_pkg::*;

    // opcodes that only the testbench needs; both read a total
    localparam logic [OPW-1:0] OP_READ     = 2'd2;
    localparam logic [OPW-1:0] OP_READ_ALT = 2'd3;

    localparam int LVLW      = $clog2(STACK_DEPTH_DEF + 1);
    localparam int HOLD_LEN  = 300;   // long receiver stall, in cycles
    localparam int HOLD_AT_A = 150;   // result counts that start a stall
    localparam int HOLD_AT_B = 450;
    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 65;

    // one request as packed into s_tdata, opcode in the low bits
    typedef struct packed {
        logic [TSW-1:0] ts;
        logic [IDW-1:0] id;
        logic [OPW-1:0] op;
    } request_t;

    // one result as packed into m_tdata, credited id in the low bits
    typedef struct packed {
        status_t         status;
        logic [TOTW-1:0] total;
        logic [IDW-1:0]  id;
    } result_t;

    // profiler state: function_count, time mark, call stack and the totals table
    typedef struct packed {
        logic [FCW-1:0]                        fc;
        logic [TSW-1:0]                        mark;
        logic [LVLW-1:0]                       lvl;
        logic [STACK_DEPTH_DEF-1:0][IDW-1:0]   stk;
        logic [NUM_FUNCS_DEF-1:0][TOTW-1:0]    tot;
    } prof_state_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [FCW-1:0]  cfg_wdata = '0;
    logic            s_tvalid  = 1'b0;
    logic            s_tready;
    logic [39:0]     s_tdata   = '0;   // opcode[1:0], func_id[5:2], timestamp[37:6], pad
    logic            m_tvalid;
    logic            m_tready  = 1'b0;
    logic [47:0]     m_tdata;          // credited_id[3:0], total_time[43:4], status[46:44], pad

    // two copies of the profile: one steered by the generator to shape the stimulus,
    // one advanced on every accepted request to predict the results
    prof_state_t gen_st;
    prof_state_t chk_st;

    request_t pending_q[$];    // requests waiting for the driver
    result_t  expected_q[$];   // predicted results, oldest first

    int issued_count = 0;
    int rx_count     = 0;
    int errors       = 0;
    int cfg_writes   = 0;
    int status_hits[5];

    int src_gap_max = 6;
    int snk_gap_max = 6;

    call_stack_exclusive_time_profiler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic prof_state_t prof_reset();
        prof_state_t st;
        st    = '0;
        st.fc = FC_RESET;
        return st;
    endfunction

    function automatic logic [TOTW-1:0] sat_add(input logic [TOTW-1:0] acc,
                                                input logic [DELTW-1:0] d);
        logic [TOTW:0] s;
        s = acc + d;
        return s[TOTW] ? TOTAL_MAX : s[TOTW-1:0];
    endfunction

    // ids at or above function_count are rejected
    function automatic logic id_valid(input logic [FCW-1:0] fc, input logic [IDW-1:0] id);
        return ({1'b0, id} < fc) && (int'(id) < NUM_FUNCS_DEF);
    endfunction

    // Advances the profile by one request and returns the result it causes.
    function automatic result_t profile_step(inout prof_state_t st, input request_t rq);
        result_t        res;
        logic [IDW-1:0] top;
        logic           popped;
        res.id     = rq.id;
        res.status = ST_OK;
        res.total  = '0;
        popped     = 1'b0;
        if (!id_valid(st.fc, rq.id))
            res.status = ST_BAD_ID;
        else if (rq.op == OP_START)
        begin
            if (st.lvl >= STACK_DEPTH_DEF)
                res.status = ST_OVERFLOW;
            else if (rq.ts < st.mark)
                res.status = ST_BACKWARDS;
            else
            begin
                // running function gets the time since the mark; empty stack just sets the mark
                if (st.lvl != 0)
                begin
                    top = st.stk[st.lvl - 1];
                    st.tot[top] = sat_add(st.tot[top], DELTW'(rq.ts) - DELTW'(st.mark));
                    res.id = top;
                end
                st.stk[st.lvl] = rq.id;
                st.lvl         = st.lvl + 1'b1;
                st.mark        = rq.ts;
            end
        end
        else if (rq.op == OP_END)
        begin
            if (st.lvl == 0)
                res.status = ST_UNDERFLOW;
            else if (rq.ts < st.mark)
                res.status = ST_BACKWARDS;
            else
            begin
                // popped function is credited whatever id the end names
                st.lvl = st.lvl - 1'b1;
                top    = st.stk[st.lvl];
                st.tot[top] = sat_add(st.tot[top],
                                      DELTW'(rq.ts) - DELTW'(st.mark) + DELTW'(1));
                st.mark = (rq.ts == TIME_MAX) ? TIME_MAX : rq.ts + 1'b1;
                res.id  = top;
                popped  = 1'b1;
            end
        end
        // a pop reports the total even if function_count has since dropped below the id
        if (popped || id_valid(st.fc, res.id))
            res.total = st.tot[res.id];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offers queued requests, predicts on each accept.
    // ------------------------------------------------------------------
    request_t cur_req;
    int       src_wait;

    always @(posedge clk or negedge rst_n)
    begin
        logic    offer;
        result_t pred;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_wait = 0;
        end
        else
        begin
            offer = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                pred = profile_step(chk_st, cur_req);
                expected_q.insert(expected_q.size(), pred);
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (src_wait > 0)
                    src_wait--;
                else if (pending_q.size() != 0)
                begin
                    cur_req  = pending_q.pop_front();
                    offer    = 1'b1;
                    src_wait = $urandom_range(0, src_gap_max);
                end
            end
            s_tvalid <= offer;
            if (offer)
                s_tdata <= {2'b00, cur_req};
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random ready, long stalls, field-by-field compare.
    // ------------------------------------------------------------------
    int snk_wait;
    int hold_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        logic    rdy;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_wait = 0;
            hold_cnt = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                rx_count++;
                if (expected_q.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.id !== want.id)
                    begin
                        $error("credited_id: expected %0d, got %0d", want.id, got.id);
                        errors++;
                    end
                    if (got.total !== want.total)
                    begin
                        $error("total_time: expected %0d, got %0d", want.total, got.total);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    status_hits[want.status]++;
                end
                snk_wait = $urandom_range(0, snk_gap_max);
                // hold off long enough that the block backs up and drops s_tready
                if (rx_count == HOLD_AT_A || rx_count == HOLD_AT_B)
                    hold_cnt = HOLD_LEN;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rdy = 1'b0;
            end
            else if (snk_wait > 0)
            begin
                snk_wait--;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            m_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_req(input logic [OPW-1:0] op, input logic [IDW-1:0] id,
                             input logic [TSW-1:0] ts);
        request_t r;
        r.op = op;
        r.id = id;
        r.ts = ts;
        void'(profile_step(gen_st, r));
        pending_q.insert(pending_q.size(), r);
        issued_count++;
    endtask

    // every request gives one result, so idle means every result has come back
    task automatic wait_idle();
        while (rx_count < issued_count)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_func_count(input logic [FCW-1:0] v);
        wait_idle();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        chk_st.fc = v;
        gen_st.fc = v;
        cfg_writes++;
    endtask

    // a timestamp at or after the mark: mostly small steps, now and then a jump
    function automatic logic [TSW-1:0] later_ts(input logic [TSW-1:0] mark);
        logic [TSW:0] t;
        int unsigned  r;
        r = $urandom_range(0, 199);
        if (r == 0)
            t = mark + ($urandom & 32'h0FFF_FFFF);
        else if (r < 8)
            t = mark + $urandom_range(0, 32'h00FF_FFFF);
        else
            t = mark + $urandom_range(0, 40);
        return (t > TIME_MAX) ? TIME_MAX : t[TSW-1:0];
    endfunction

    function automatic logic [TSW-1:0] earlier_ts(input logic [TSW-1:0] mark);
        return (mark == 0) ? '0 : $urandom % mark;
    endfunction

    function automatic logic [IDW-1:0] good_id();
        int vmax;
        vmax = (gen_st.fc > NUM_FUNCS_DEF) ? NUM_FUNCS_DEF : gen_st.fc;
        return (vmax == 0) ? IDW'($urandom) : IDW'($urandom_range(0, vmax - 1));
    endfunction

    // mostly well-formed starts and ends, with reads, noise and backwards times mixed in
    task automatic random_req();
        int unsigned    r;
        logic [IDW-1:0] vid;
        vid = good_id();
        r   = $urandom_range(0, 99);
        if (r < 40)
            queue_req(OP_START, vid, later_ts(gen_st.mark));
        else if (r < 72)
            queue_req(OP_END, vid, later_ts(gen_st.mark));
        else if (r < 84)
            queue_req(r[0] ? OP_READ : OP_READ_ALT, IDW'($urandom), $urandom);
        else if (r < 92)
            queue_req(OPW'($urandom_range(0, 3)), IDW'($urandom), earlier_ts(gen_st.mark));
        else
            queue_req(r[0] ? OP_START : OP_END, vid, earlier_ts(gen_st.mark));
    endtask

    // fill the stack, push once more into a full stack, end with a backwards time, then unwind it
    task automatic deep_dive();
        while (gen_st.lvl < STACK_DEPTH_DEF)
            queue_req(OP_START, good_id(), later_ts(gen_st.mark));
        queue_req(OP_START, good_id(), later_ts(gen_st.mark));
        queue_req(OP_END, good_id(), earlier_ts(gen_st.mark));
        while (gen_st.lvl != 0)
            queue_req(OP_END, good_id(), later_ts(gen_st.mark));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [FCW-1:0] phase_fc[PHASES];
        int             phase_src[PHASES];
        int             phase_snk[PHASES];
        gen_st = prof_reset();
        chk_st = prof_reset();
        phase_fc  = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd12, 5'd16};
        phase_src = '{6, 0, 0, 6, 6, 3};
        phase_snk = '{6, 0, 6, 0, 6, 3};
        phase_fc[PHASES-1] = FCW'($urandom_range(1, 16));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty-stack cases, credit rules, ignored end id, both read codes
        queue_req(OP_READ,     4'd0,  TIME_MAX);
        queue_req(OP_END,      4'd15, 32'd0);      // end on empty stack
        queue_req(OP_START,    4'd0,  32'd0);      // start on empty stack sets the mark
        queue_req(OP_START,    4'd15, 32'd10);     // credits 0
        queue_req(OP_END,      4'd3,  32'd20);     // pops 15 regardless of the id
        queue_req(OP_END,      4'd0,  32'd15);     // time backwards
        queue_req(OP_START,    4'd5,  32'd21);     // zero credit
        queue_req(OP_READ_ALT, 4'd15, 32'd0);
        queue_req(OP_END,      4'd5,  32'd30);
        queue_req(OP_END,      4'd0,  32'd31);
        queue_req(OP_START,    4'd2,  32'd100);    // mark moves on an empty-stack start
        queue_req(OP_END,      4'd2,  32'd100);
        queue_req(OP_START,    4'd1,  32'd200);
        queue_req(OP_START,    4'd12, 32'd210);

        // id 12 stays on the stack after function_count drops below it
        set_func_count(5'd4);
        queue_req(OP_START,    4'd2,  32'd220);    // credits 12, reported total is 0
        queue_req(OP_READ,     4'd12, 32'd0);      // bad id
        queue_req(OP_END,      4'd0,  32'd230);
        queue_req(OP_END,      4'd0,  32'd240);    // pops 12, total still reported
        queue_req(OP_END,      4'd0,  32'd250);
        queue_req(OP_START,    4'd9,  32'd260);    // bad id

        // zero count rejects every id
        set_func_count(5'd0);
        queue_req(OP_READ,     4'd0,  32'd0);
        queue_req(OP_START,    4'd0,  32'd300);

        // counts above the table size are capped by it
        set_func_count(5'd31);
        queue_req(OP_START,    4'd15, 32'd300);
        queue_req(OP_END,      4'd15, 32'd300);

        // random phases, each with its own count and idling pattern
        for (int p = 0; p < PHASES; p++)
        begin
            set_func_count(phase_fc[p]);
            src_gap_max = phase_src[p];
            snk_gap_max = phase_snk[p];
            if (p == 3)
                deep_dive();
            for (int i = 0; i < PHASE_LEN; i++)
                random_req();
        end

        // closing: unwind, then an end at the last tick saturates the mark
        set_func_count(5'd16);
        src_gap_max = 6;
        snk_gap_max = 6;
        while (gen_st.lvl != 0)
            queue_req(OP_END, good_id(), later_ts(gen_st.mark));
        queue_req(OP_START, 4'd3, TIME_MAX - 1'b1);
        queue_req(OP_END,   4'd3, TIME_MAX);
        queue_req(OP_START, 4'd4, TIME_MAX);
        queue_req(OP_END,   4'd4, TIME_MAX);       // credits one tick
        queue_req(OP_READ,  4'd4, 32'd0);
        queue_req(OP_READ,  4'd3, 32'd0);

        wait_idle();
        repeat (20) @(posedge clk);

        $display("Ran %0d requests across %0d function_count writes; %0d results checked.",
                 issued_count, cfg_writes, rx_count);
        $display("Status mix: ok %0d, bad id %0d, overflow %0d, empty-stack end %0d, backwards %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (errors == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
